// ----- rtl/cp1d_pkg.sv -----
// ----------------------------------------------------------------------------
// cp1d_pkg
// Shared types and constants for the one-dimensional closest pair block.
// ----------------------------------------------------------------------------
package cp1d_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int POS_W       = $clog2(MAX_ITEMS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int DIST_W      = 32;

  typedef struct packed {
    logic                   vld;
    logic [VALUE_WIDTH-1:0] key;
    logic [POS_W-1:0]       pos;
  } cell_t;

  typedef struct packed {
    logic ins;
    logic shf;
    logic clr;
  } cell_ctl_t;

  typedef struct packed {
    logic                   start;
    logic                   step;
  } scan_ctl_t;

  typedef struct packed {
    logic                   found;
    logic [VALUE_WIDTH-1:0] gap;
    logic [POS_W-1:0]       first;
    logic [POS_W-1:0]       second;
  } best_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/cp1d_cell.sv -----
// ----------------------------------------------------------------------------
// cp1d_cell
// One sorting cell. It inserts a new key in order, shifts toward the head and clears.
// ----------------------------------------------------------------------------
module cp1d_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cp1d_pkg::cell_ctl_t        ctl,
  input  cp1d_pkg::cell_t            new_item,
  input  cp1d_pkg::cell_t            prev_item,
  input  logic                       prev_gt,
  input  cp1d_pkg::cell_t            next_item,
  output cp1d_pkg::cell_t            item,
  output logic                       gt
);
  import cp1d_pkg::*;

  cell_t item_r;
  cell_t item_nxt;

  // An empty cell behaves as a key above every value, so equal keys stay in order.
  assign gt   = !item_r.vld || (item_r.key > new_item.key);
  assign item = item_r;

  always_comb begin
    item_nxt = item_r;
    if (ctl.clr) begin
      item_nxt.vld = 1'b0;
    end else if (ctl.ins) begin
      if (gt) begin
        item_nxt = prev_gt ? prev_item : new_item;
      end
    end else if (ctl.shf) begin
      item_nxt = next_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else begin
      item_r.vld <= item_nxt.vld;
    end
    item_r.key <= item_nxt.key;
    item_r.pos <= item_nxt.pos;
  end

endmodule

// ----- rtl/cp1d_scan.sv -----
// ----------------------------------------------------------------------------
// cp1d_scan
// Head-of-chain scanner. It tracks the first adjacent pair with the smallest gap.
// ----------------------------------------------------------------------------
module cp1d_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cp1d_pkg::scan_ctl_t   ctl,
  input  cp1d_pkg::cell_t       head0,
  input  cp1d_pkg::cell_t       head1,
  output cp1d_pkg::best_t       best
);
  import cp1d_pkg::*;

  logic                   pair_vld_r;
  logic [VALUE_WIDTH-1:0] pair_d_r;
  logic [POS_W-1:0]       pair_p0_r;
  logic [POS_W-1:0]       pair_p1_r;
  best_t                  best_r;
  best_t                  best_nxt;

  assign best = best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_vld_r <= 1'b0;
    end else begin
      pair_vld_r <= ctl.step && !ctl.start;
    end
  end

  always_ff @(posedge clk) begin
    pair_d_r  <= head1.key - head0.key;
    pair_p0_r <= head0.pos;
    pair_p1_r <= head1.pos;
  end

  always_comb begin
    best_nxt = best_r;
    if (ctl.start) begin
      best_nxt = '0;
    end else if (pair_vld_r) begin
      if (!best_r.found || (pair_d_r < best_r.gap)) begin
        best_nxt.found  = 1'b1;
        best_nxt.gap    = pair_d_r;
        best_nxt.first  = pair_p0_r;
        best_nxt.second = pair_p1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else begin
      best_r <= best_nxt;
    end
  end

endmodule

// ----- rtl/closest_pair_1d_by_sort.sv -----
// ----------------------------------------------------------------------------
// closest_pair_1d_by_sort
// Closest pair of a set of signed values, by insertion sort in a cell chain.
// ----------------------------------------------------------------------------
// Values enter one transaction per cycle while the block is loading and are
// inserted in sorted order into a chain of 1024 cells as they arrive.
// After the transaction marked last, the chain shifts toward its head one cell
// per cycle while the head pair is compared; the length of that shift is what
// sets the per-set time. Equal values keep their arrival order, and on equal
// gaps the earliest pair in sorted order is reported. Items arriving after
// 1024 are stored are dropped and flagged as truncated. No input is taken
// from the last transaction until the result has been loaded into the output
// register, which then waits for the consumer while the next set loads.
// ----------------------------------------------------------------------------
module closest_pair_1d_by_sort (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [9:0]                        out_first_position,
  output logic [9:0]                        out_second_position,
  output logic [31:0]                       out_distance,
  output logic                              out_truncated
);
  import cp1d_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic             in_fire;
  logic             full;
  logic             emit_go;
  cell_ctl_t        cell_ctl;
  scan_ctl_t        scan_ctl;
  cell_t            new_item;
  cell_t            cells [MAX_ITEMS];
  logic             gts   [MAX_ITEMS];
  best_t            best;

  logic             out_valid_r;
  logic             out_found_r;
  logic [9:0]       out_first_r;
  logic [9:0]       out_second_r;
  logic [31:0]      out_dist_r;
  logic             out_trunc_r;

  assign full    = (count_r == CNT_W'(MAX_ITEMS));
  assign in_fire = in_valid && in_ready;

  always_comb begin
    new_item.vld = 1'b1;
    new_item.key = {~in_value[VALUE_WIDTH-1], in_value[VALUE_WIDTH-2:0]};
    new_item.pos = count_r[POS_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!cells[1].vld) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    emit_go        = 1'b0;
    cell_ctl       = '0;
    scan_ctl       = '0;
    case (state_r)
      ST_LOAD: begin
        in_ready       = 1'b1;
        cell_ctl.ins   = in_fire && !full;
        scan_ctl.start = in_fire && in_last;
      end
      ST_SCAN: begin
        cell_ctl.shf  = 1'b1;
        scan_ctl.step = cells[1].vld;
      end
      ST_EMIT: begin
        emit_go      = !out_valid_r || out_ready;
        cell_ctl.clr = emit_go;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (emit_go) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (in_fire) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
    cell_t prev_item;
    logic  prev_gt;
    cell_t next_item;

    if (gi == 0) begin : g_head
      assign prev_item = '0;
      assign prev_gt   = 1'b0;
    end else begin : g_body
      assign prev_item = cells[gi-1];
      assign prev_gt   = gts[gi-1];
    end

    if (gi == MAX_ITEMS - 1) begin : g_tail
      assign next_item = '0;
    end else begin : g_link
      assign next_item = cells[gi+1];
    end

    cp1d_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .new_item  (new_item),
      .prev_item (prev_item),
      .prev_gt   (prev_gt),
      .next_item (next_item),
      .item      (cells[gi]),
      .gt        (gts[gi])
    );
  end

  cp1d_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .head0 (cells[0]),
    .head1 (cells[1]),
    .best  (best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_found_r  <= best.found;
      out_first_r  <= 10'(best.first);
      out_second_r <= 10'(best.second);
      out_dist_r   <= DIST_W'(best.gap);
      out_trunc_r  <= ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_first_position  = out_first_r;
  assign out_second_position = out_second_r;
  assign out_distance        = out_dist_r;
  assign out_truncated       = out_trunc_r;

endmodule

// ----- rtl/cp1d_checker.sv -----
// ----------------------------------------------------------------------------
// cp1d_checker
// Port-level checks for the closest pair block, bound to the top level.
// ----------------------------------------------------------------------------
module cp1d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [9:0]  out_first_position,
  input logic [9:0]  out_second_position,
  input logic [31:0] out_distance
);

  // A result that is not taken stays valid and keeps its found flag and distance.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance)
      && $stable(out_found))
    else $error("result changed while stalled");

  // The last transaction of a set starts the search, so input stalls next.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input accepted during search");

  // An empty result carries zero fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_distance == 32'd0
      && out_first_position == 10'd0 && out_second_position == 10'd0)
    else $error("empty result has nonzero fields");

  // A pair always names two distinct arrival positions.
  a_pair_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_first_position != out_second_position)
    else $error("pair positions coincide");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind closest_pair_1d_by_sort cp1d_checker u_cp1d_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_last             (in_last),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_found           (out_found),
  .out_first_position  (out_first_position),
  .out_second_position (out_second_position),
  .out_distance        (out_distance)
);

// ----- tb/sv/cp1d_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// cp1d_tb_pkg
// Scoreboard for the one-dimensional closest pair block.
// ----------------------------------------------------------------------------
// Collects the values of each set as its input transactions are accepted.
// When the set is closed it predicts the closest pair by a stable sort and a
// scan of sorted neighbors, then checks every result transaction in order
// against those predictions.
// ----------------------------------------------------------------------------
package cp1d_tb_pkg;

  import cp1d_pkg::MAX_ITEMS;

  typedef struct {
    logic        found;
    logic [9:0]  first_pos;
    logic [9:0]  second_pos;
    logic [31:0] gap;
    logic        truncated;
  } pair_result_t;

  class closest_pair_scoreboard;
    logic signed [31:0] set_values[$];
    bit                 set_dropped;
    pair_result_t       expected_pairs[$];
    int                 mismatches;
    int                 items_seen;
    int                 sets_closed;
    int                 truncated_sets;
    int                 largest_set;
    int                 results_checked;

    function pair_result_t find_closest_pair();
      longint       keys[];
      int           order[];
      longint       k;
      longint       best;
      longint       d;
      int           n;
      int           j;
      pair_result_t r;
      r = '{found: 1'b0, first_pos: '0, second_pos: '0, gap: '0, truncated: set_dropped};
      n = set_values.size();
      keys = new[n];
      order = new[n];
      for (int i = 0; i < n; i++) begin
        k = set_values[i];
        j = i;
        while (j > 0 && keys[j-1] > k) begin
          keys[j] = keys[j-1];
          order[j] = order[j-1];
          j--;
        end
        keys[j] = k;
        order[j] = i;
      end
      if (n >= 2) begin
        r.found = 1'b1;
        best = keys[1] - keys[0];
        r.first_pos = 10'(order[0]);
        r.second_pos = 10'(order[1]);
        for (int i = 1; i + 1 < n; i++) begin
          d = keys[i+1] - keys[i];
          if (d < best) begin
            best = d;
            r.first_pos = 10'(order[i]);
            r.second_pos = 10'(order[i+1]);
          end
        end
        r.gap = best[31:0];
      end
      return r;
    endfunction

    function void note_input(logic signed [31:0] value, logic last);
      items_seen++;
      if (set_values.size() < MAX_ITEMS) begin
        set_values.push_back(value);
      end else begin
        set_dropped = 1'b1;
      end
      if (last) begin
        expected_pairs.push_back(find_closest_pair());
        sets_closed++;
        if (set_dropped) begin
          truncated_sets++;
        end
        if (set_values.size() > largest_set) begin
          largest_set = set_values.size();
        end
        set_values.delete();
        set_dropped = 1'b0;
      end
    endfunction

    task report(string what);
      if (mismatches < 100) begin
        $display("mismatch at result %0d: %s", results_checked, what);
      end
      mismatches++;
    endtask

    task check_result(logic found, logic [9:0] first_pos, logic [9:0] second_pos,
                      logic [31:0] distance, logic truncated);
      pair_result_t e;
      results_checked++;
      if (expected_pairs.size() == 0) begin
        report($sformatf("result with no set pending (found=%b first=%0d second=%0d)",
                         found, first_pos, second_pos));
        return;
      end
      e = expected_pairs.pop_front();
      if (found !== e.found) begin
        report($sformatf("found %b, expected %b", found, e.found));
      end
      if (first_pos !== e.first_pos) begin
        report($sformatf("first_position %0d, expected %0d", first_pos, e.first_pos));
      end
      if (second_pos !== e.second_pos) begin
        report($sformatf("second_position %0d, expected %0d", second_pos, e.second_pos));
      end
      if (distance !== e.gap) begin
        report($sformatf("distance %h, expected %h", distance, e.gap));
      end
      if (truncated !== e.truncated) begin
        report($sformatf("truncated %b, expected %b", truncated, e.truncated));
      end
    endtask
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for closest_pair_1d_by_sort.
// ----------------------------------------------------------------------------
// Sends a few directed sets covering extreme values, single items, equal
// values and equal gaps, then random sets of mostly small sizes. Both
// channels idle at random, the result side once holds off long enough to
// stall the input, and every result transaction is checked against the
// scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cp1d_tb_pkg::*;

  localparam int IDLE_LIMIT     = 20000;
  localparam int HOLD_CYCLES    = 800;
  localparam int HOLD_AT_RESULT = 12;
  localparam int RANDOM_ITEMS   = 630;
  localparam int DRAIN_CYCLES   = cp1d_pkg::MAX_ITEMS + 64;

  typedef enum int {
    MIX_WIDE,
    MIX_NARROW,
    MIX_EXTREME,
    MIX_CLUSTER
  } value_mix_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic signed [31:0] in_value  = '0;
  logic               in_last   = 1'b0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               out_found;
  logic [9:0]         out_first_position;
  logic [9:0]         out_second_position;
  logic [31:0]        out_distance;
  logic               out_truncated;
  int                 idle_cycles = 0;

  closest_pair_scoreboard sb;

  closest_pair_1d_by_sort u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_value            (in_value),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_found           (out_found),
    .out_first_position  (out_first_position),
    .out_second_position (out_second_position),
    .out_distance        (out_distance),
    .out_truncated       (out_truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input logic signed [31:0] value, input logic last, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_last  <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_input(value, last);
  endtask

  task automatic send_list(input logic signed [31:0] vals[$]);
    for (int i = 0; i < vals.size(); i++) begin
      send_item(vals[i], i == vals.size() - 1, $urandom_range(0, 19));
    end
  endtask

  function automatic logic signed [31:0] pick_value(value_mix_t mix, logic signed [31:0] base);
    case (mix)
      MIX_WIDE: begin
        return $urandom;
      end
      MIX_NARROW: begin
        return $signed($urandom_range(0, 40)) - 20;
      end
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return $urandom;
        endcase
      end
      default: begin
        return base + $signed($urandom_range(0, 1000));
      end
    endcase
  endfunction

  task automatic send_set(input int n, input value_mix_t mix, input bit burst);
    logic signed [31:0] base;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      send_item(pick_value(mix, base), i == n - 1, burst ? 0 : $urandom_range(0, 19));
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_pairs.size() != 0);
  endtask

  function automatic int draw_set_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) begin
      return $urandom_range(1, 12);
    end else if (r < 19) begin
      return $urandom_range(13, 40);
    end
    return $urandom_range(41, 100);
  endfunction

  initial begin : stimulus
    int n;
    int set_idx;
    int sent;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_list('{32'sh7fff_ffff});
    send_list('{32'sh8000_0000, 32'sh7fff_ffff});
    send_list('{32'sd5, 32'sd5, 32'sd5});
    send_list('{32'sd30, 32'sd0, 32'sd20, 32'sd10});
    send_list('{-32'sd1, 32'sd0, 32'sh8000_0000, 32'sh8000_0001, 32'sd1, 32'sh7fff_ffff});
    send_list('{32'sd0, 32'sd0});

    set_idx = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = draw_set_size();
      send_set(n, value_mix_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      sent += n;
      if (set_idx == 20) begin
        wait_all_results();
      end
      set_idx++;
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_pairs.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_pairs.size()));
    end
    $display("Covered %0d sets from %0d input transactions; %0d sets truncated, largest %0d.",
             sb.sets_closed, sb.items_seen, sb.truncated_sets, sb.largest_set);
    $display("Checked %0d result transactions, %0d mismatches.",
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS closest_pair_1d_by_sort");
    end else begin
      $display("FAIL closest_pair_1d_by_sort");
    end
    $finish;
  end

  initial begin : result_sink
    int  gap;
    int  taken;
    bit  burst;
    taken = 0;
    burst = 1'b0;
    repeat (6) @(posedge clk);
    forever begin
      if (taken % 16 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      if (taken == HOLD_AT_RESULT) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_found, out_first_position, out_second_position,
                      out_distance, out_truncated);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("No transaction for %0d cycles, stopping.", IDLE_LIMIT);
        $display("FAIL closest_pair_1d_by_sort");
        $finish;
      end
    end
  end

endmodule
